/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers. Define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The condition must never hold at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed: forbidden condition seen");

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: expected follow-up missing");

`else

`define ASSERT_NEVER(label, clk, rst_n, cond)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* hw/rtl/qts_pkg.sv */
// ----------------------------------------------------------------------------
// qts_pkg
// Types, character codes and helper functions of the quoted token scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package qts_pkg;

  localparam int unsigned CountWidth = 16;
  localparam int unsigned LenWidth   = 16;
  localparam int unsigned WideWidth  = (CountWidth > LenWidth) ? CountWidth : LenWidth;

  typedef logic [CountWidth-1:0] count_t;
  typedef logic [LenWidth-1:0]   len_t;
  typedef logic [7:0]            char_t;

  localparam len_t MaxLenReset = len_t'(255);

  localparam char_t ChNul       = 8'h00;
  localparam char_t ChTab       = 8'h09;
  localparam char_t ChLf        = 8'h0A;
  localparam char_t ChVt        = 8'h0B;
  localparam char_t ChFf        = 8'h0C;
  localparam char_t ChCr        = 8'h0D;
  localparam char_t ChSpace     = 8'h20;
  localparam char_t ChDquote    = 8'h22;
  localparam char_t ChSquote    = 8'h27;
  localparam char_t ChComma     = 8'h2C;
  localparam char_t ChZero      = 8'h30;
  localparam char_t ChEqual     = 8'h3D;
  localparam char_t ChBackslash = 8'h5C;
  localparam char_t ChLowF      = 8'h66;
  localparam char_t ChLowN      = 8'h6E;
  localparam char_t ChLowR      = 8'h72;
  localparam char_t ChLowX      = 8'h78;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WS,
    PH_UQ,
    PH_Q,
    PH_QS,
    PH_ESC,
    PH_HEX1,
    PH_HEX2
  } phase_e;

  typedef struct packed {
    logic  start_req;
    char_t ch;
  } item_t;

  typedef struct packed {
    char_t out_byte;
    logic  byte_valid;
    logic  done_res;
    logic  ok;
    len_t  scanned_len;
    len_t  consumed_len;
  } result_t;

  function automatic count_t sat_inc(count_t c);
    return (c == '1) ? c : c + count_t'(1);
  endfunction

  // Reported lengths saturate at the width of the length fields.
  function automatic len_t report_len(count_t c);
    logic [WideWidth-1:0] w;
    w = WideWidth'(c);
    if (w > WideWidth'({LenWidth{1'b1}})) begin
      return '1;
    end
    return w[LenWidth-1:0];
  endfunction

  function automatic logic at_limit(count_t c, len_t m);
    return WideWidth'(c) >= WideWidth'(m);
  endfunction

  // Bit 4 set marks a character that is not a hex digit.
  function automatic logic [4:0] hex_val(char_t c);
    char_t d;
    d = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      return {1'b0, d[3:0]};
    end
    if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      return {1'b0, d[3:0]};
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      return {1'b0, d[3:0]};
    end
    return 5'h10;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/qts_in_stage.sv */
// ----------------------------------------------------------------------------
// qts_in_stage
// Input register of the scanner: holds one accepted character transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module qts_in_stage import qts_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t item_i,
  input  logic  advance_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  load;

  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

/* hw/rtl/qts_engine.sv */
// ----------------------------------------------------------------------------
// qts_engine
// Scan state and the single-character step: whitespace skip, unquoted and
// quoted token copy, escapes, hex decode and the one-byte hold buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module qts_engine import qts_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  item_t   item_i,
  input  len_t    max_len_i,
  output logic    res_valid_o,
  output result_t res_o
);

  phase_e     phase_q, phase_d;
  char_t      quote_q, quote_d;
  count_t     tok_cnt_q, tok_cnt_d;
  count_t     cons_cnt_q, cons_cnt_d;
  logic [3:0] hex_hi_q, hex_hi_d;
  logic       hold_valid_q, hold_valid_d;
  char_t      hold_byte_q, hold_byte_d;

  always_comb begin
    phase_e     cur;
    char_t      c;
    logic       active;
    logic       do_uq;
    logic       do_q;
    logic       e0_v, e1_v;
    char_t      e0_b, e1_b;
    logic       fin, fin_ok;
    logic [4:0] hv;
    logic       q0_v, q1_v;
    char_t      q0_b, q1_b;

    c            = item_i.ch;
    phase_d      = phase_q;
    quote_d      = quote_q;
    tok_cnt_d    = tok_cnt_q;
    cons_cnt_d   = cons_cnt_q;
    hex_hi_d     = hex_hi_q;
    hold_valid_d = hold_valid_q;
    hold_byte_d  = hold_byte_q;
    active       = 1'b1;
    do_uq        = 1'b0;
    do_q         = 1'b0;
    e0_v         = 1'b0;
    e1_v         = 1'b0;
    e0_b         = '0;
    e1_b         = '0;
    fin          = 1'b0;
    fin_ok       = 1'b0;
    hv           = hex_val(c);

    // A start abandons any scan in progress, held byte included.
    if (item_i.start_req) begin
      cur          = PH_WS;
      quote_d      = '0;
      tok_cnt_d    = '0;
      cons_cnt_d   = '0;
      hex_hi_d     = '0;
      hold_valid_d = 1'b0;
      hold_byte_d  = '0;
    end else begin
      cur = phase_q;
    end
    phase_d = cur;

    unique case (cur)
      PH_IDLE: begin
        active = 1'b0;
      end
      PH_WS: begin
        if (c == ChSpace || c == ChTab || c == ChLf || c == ChVt ||
            c == ChFf || c == ChCr) begin
          cons_cnt_d = sat_inc(cons_cnt_d);
        end else if (c == ChNul) begin
          fin    = 1'b1;
          fin_ok = 1'b1;
        end else if (c == ChDquote || c == ChSquote) begin
          cons_cnt_d = sat_inc(cons_cnt_d);
          quote_d    = c;
          phase_d    = PH_Q;
        end else begin
          phase_d = PH_UQ;
          do_uq   = 1'b1;
        end
      end
      PH_UQ: begin
        do_uq = 1'b1;
      end
      PH_Q: begin
        do_q = 1'b1;
      end
      PH_QS: begin
        if (c == quote_d) begin
          cons_cnt_d = sat_inc(cons_cnt_d);
          e0_v       = 1'b1;
          e0_b       = c;
          tok_cnt_d  = sat_inc(tok_cnt_d);
          phase_d    = PH_Q;
        end else begin
          fin    = 1'b1;
          fin_ok = 1'b1;
        end
      end
      PH_ESC: begin
        phase_d = PH_Q;
        if (c == quote_d || c == ChZero || c == ChLowF || c == ChLowN || c == ChLowR) begin
          cons_cnt_d = sat_inc(cons_cnt_d);
          e0_v       = 1'b1;
          tok_cnt_d  = sat_inc(tok_cnt_d);
          priority if (c == quote_d) begin
            e0_b = c;
          end else if (c == ChZero) begin
            e0_b = ChNul;
          end else if (c == ChLowF) begin
            e0_b = ChFf;
          end else if (c == ChLowN) begin
            e0_b = ChLf;
          end else begin
            e0_b = ChCr;
          end
        end else if (c == ChLowX) begin
          cons_cnt_d = sat_inc(cons_cnt_d);
          phase_d    = PH_HEX1;
        end else begin
          // Unknown escape: the backslash is copied and the character is
          // treated as an ordinary quoted character.
          e0_v      = 1'b1;
          e0_b      = ChBackslash;
          tok_cnt_d = sat_inc(tok_cnt_d);
          do_q      = 1'b1;
        end
      end
      PH_HEX1: begin
        cons_cnt_d = sat_inc(cons_cnt_d);
        if (hv[4]) begin
          fin = 1'b1;
        end else begin
          hex_hi_d = hv[3:0];
          phase_d  = PH_HEX2;
        end
      end
      PH_HEX2: begin
        cons_cnt_d = sat_inc(cons_cnt_d);
        if (hv[4]) begin
          fin = 1'b1;
        end else begin
          e0_v      = 1'b1;
          e0_b      = {hex_hi_q, hv[3:0]};
          tok_cnt_d = sat_inc(tok_cnt_d);
          phase_d   = PH_Q;
        end
      end
    endcase

    if (do_uq) begin
      if (c == ChNul || c == ChEqual || c == ChComma || c == ChSpace || c == ChTab) begin
        fin    = 1'b1;
        fin_ok = 1'b1;
      end else begin
        cons_cnt_d = sat_inc(cons_cnt_d);
        if (!at_limit(tok_cnt_d, max_len_i)) begin
          e0_v      = 1'b1;
          e0_b      = c;
          tok_cnt_d = sat_inc(tok_cnt_d);
        end
      end
    end

    if (do_q) begin
      if (at_limit(tok_cnt_d, max_len_i)) begin
        if (c != ChNul) begin
          cons_cnt_d = sat_inc(cons_cnt_d);
        end
        fin    = 1'b1;
        fin_ok = 1'b1;
      end else if (c == ChNul) begin
        fin    = 1'b1;
        fin_ok = 1'b1;
      end else begin
        cons_cnt_d = sat_inc(cons_cnt_d);
        if (c == quote_d) begin
          phase_d = PH_QS;
        end else if (c == ChBackslash) begin
          phase_d = PH_ESC;
        end else begin
          if (!e0_v) begin
            e0_v = 1'b1;
            e0_b = c;
          end else begin
            e1_v = 1'b1;
            e1_b = c;
          end
          tok_cnt_d = sat_inc(tok_cnt_d);
        end
      end
    end

    if (fin) begin
      phase_d = PH_IDLE;
    end

    // Byte order: held byte first, then the bytes of this character.
    q0_v = hold_valid_d || e0_v;
    q0_b = hold_valid_d ? hold_byte_d : e0_b;
    q1_v = hold_valid_d ? e0_v : e1_v;
    q1_b = hold_valid_d ? e0_b : e1_b;

    if (active) begin
      hold_valid_d = q1_v;
      hold_byte_d  = q1_v ? q1_b : '0;
    end

    res_valid_o        = active && (q0_v || fin);
    res_o.out_byte     = q0_v ? q0_b : '0;
    res_o.byte_valid   = q0_v;
    res_o.done_res     = fin;
    res_o.ok           = fin && fin_ok;
    res_o.scanned_len  = fin ? report_len(tok_cnt_d) : '0;
    res_o.consumed_len = fin ? report_len(cons_cnt_d) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      quote_q      <= '0;
      tok_cnt_q    <= '0;
      cons_cnt_q   <= '0;
      hex_hi_q     <= '0;
      hold_valid_q <= 1'b0;
      hold_byte_q  <= '0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      quote_q      <= quote_d;
      tok_cnt_q    <= tok_cnt_d;
      cons_cnt_q   <= cons_cnt_d;
      hex_hi_q     <= hex_hi_d;
      hold_valid_q <= hold_valid_d;
      hold_byte_q  <= hold_byte_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/quoted_token_scanner_core.sv */
// ----------------------------------------------------------------------------
// quoted_token_scanner_core
// Streaming scanner that extracts one optionally quoted token per scan.
// ----------------------------------------------------------------------------
// One character enters per transaction and the block sustains one character
// per clock cycle unless a result waits on a stalled output. Each character
// is held in the input register, where the scan state machine processes it,
// and its result, if any, moves into the output register. The scan state
// (phase, counters, one-byte hold buffer) is updated as each character moves
// on, which sets this rate. A character that produces no result leaves the
// pipeline even while the output is stalled. max_len may be written only
// while no scan is pending.
`default_nettype none

`include "assert_macros.svh"

module quoted_token_scanner_core import qts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        start_req_i,
  input  logic [7:0]  ch_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        byte_valid_o,
  output logic        done_res_o,
  output logic        ok_o,
  output logic [15:0] scanned_len_o,
  output logic [15:0] consumed_len_o
);

  len_t    max_len_q;
  item_t   in_item;
  item_t   stage_item;
  logic    stage_valid;
  logic    advance;
  logic    res_valid;
  result_t res;
  logic    out_valid_q, out_valid_d;
  result_t out_q;
  logic    out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
    end else if (cfg_we_i) begin
      max_len_q <= len_t'(cfg_wdata_i);
    end
  end

  assign in_item.start_req = start_req_i;
  assign in_item.ch        = ch_i;

  qts_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .advance_i  (advance),
    .valid_o    (stage_valid),
    .item_o     (stage_item)
  );

  qts_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (stage_item),
    .max_len_i   (max_len_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // The staged character moves on when its result has a free slot or it has no result.
  assign out_free = !out_valid_q || out_ready_i;
  assign advance  = stage_valid && (out_free || !res_valid);

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_q.out_byte;
  assign byte_valid_o   = out_q.byte_valid;
  assign done_res_o     = out_q.done_res;
  assign ok_o           = out_q.ok;
  assign scanned_len_o  = out_q.scanned_len;
  assign consumed_len_o = out_q.consumed_len;

  // Every result carries a byte, a scan end, or both.
  `ASSERT_NEVER(a_res_not_empty, clk_i, rst_ni, out_valid_o && !byte_valid_o && !done_res_o)

  // Status fields are zero unless the result ends a scan.
  `ASSERT_NEVER(a_status_only_done, clk_i, rst_ni,
                out_valid_o && !done_res_o &&
                (ok_o || scanned_len_o != 16'd0 || consumed_len_o != 16'd0))

  // A result without a byte shows a zero byte.
  `ASSERT_NEVER(a_byte_zero, clk_i, rst_ni, out_valid_o && !byte_valid_o && out_byte_o != 8'd0)

  // A staged character that cannot move on stays staged.
  `ASSERT_NEXT(a_stage_kept, clk_i, rst_ni, stage_valid && !advance, stage_valid)

endmodule

`default_nettype wire
